// File: hdl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg - shared definitions for the input source route table
// Table geometry, command and status codes, entry layout and the structs
// that pass between the lookup engine and the statistics unit.
// ----------------------------------------------------------------------------
package irt_pkg;

	// Table geometry
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Field widths
	localparam int KIND_W   = 3;
	localparam int HANDLE_W = 32;
	localparam int WS_W     = 32;
	localparam int DTYPE_W  = 8;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 7;
	localparam int CTR_W    = 32;

	// Stream widths
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = KIND_W;
	localparam int M_TDATA_W = 136;
	localparam int M_TUSER_W = STATUS_W;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd2;
	localparam logic [KIND_W-1:0] KIND_KEY    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MOUSE  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;

	// Device types and the empty workspace marker
	localparam logic [DTYPE_W-1:0] TYPE_KEYBOARD = 8'd1;
	localparam logic [DTYPE_W-1:0] TYPE_MOUSE    = 8'd2;
	localparam logic [WS_W-1:0]    NO_WS         = 32'hFFFF_FFFF;

	// One table entry as stored in memory
	typedef struct packed {
		logic [DTYPE_W-1:0]  dtype;
		logic [WS_W-1:0]     ws;
		logic [HANDLE_W-1:0] handle;
	} irt_entry_t;

	// Completion event from the engine to the statistics unit
	typedef struct packed {
		logic fire;
		logic is_packet;
		logic is_clear;
	} irt_evt_t;

	// Counter values after the current item
	typedef struct packed {
		logic [CTR_W-1:0] routed;
		logic [CTR_W-1:0] blocked;
		logic [CTR_W-1:0] total;
	} irt_cnt_t;

endpackage

// File: hdl/irt_engine.sv
// ----------------------------------------------------------------------------
// irt_engine - table memory and scan sequencer
// Scans the live entries one per cycle through a synchronous memory, finds
// the first match, compacts the table on remove and writes back on assign.
// ----------------------------------------------------------------------------
module irt_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [irt_pkg::KIND_W-1:0]      cmd_kind,
	input  logic [irt_pkg::HANDLE_W-1:0]    cmd_handle,
	input  logic [irt_pkg::WS_W-1:0]        cmd_ws,
	input  logic [irt_pkg::DTYPE_W-1:0]     cmd_dtype,
	input  logic                            res_ready,
	output logic                            res_valid,
	output logic [irt_pkg::STATUS_W-1:0]    res_status,
	output logic [irt_pkg::WS_W-1:0]        res_found,
	output logic [irt_pkg::CNT_W-1:0]       res_count,
	output irt_pkg::irt_evt_t               evt
);
	import irt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} irt_state_t;

	irt_state_t            state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [WS_W-1:0]       ws_q;
	logic [DTYPE_W-1:0]    dtype_q;
	logic [CNT_W-1:0]      live_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_addr_s1;
	irt_entry_t            rd_data_s1;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [WS_W-1:0]       hit_ws_q;
	irt_entry_t            entry_mem_q [DEPTH];

	logic                  issue;
	logic                  is_pkt;
	logic [DTYPE_W-1:0]    want_type;
	logic                  cmp_match;
	logic                  shift_wr;
	logic                  scan_end;
	logic                  fin;
	logic                  is_full;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	irt_entry_t            wr_data;
	logic [CNT_W-1:0]      live_next;

	// Scan control
	assign issue     = (state_q == ST_SCAN) && (rd_cnt_q < live_q);
	assign is_pkt    = (kind_q == KIND_KEY) || (kind_q == KIND_MOUSE);
	assign want_type = (kind_q == KIND_KEY) ? TYPE_KEYBOARD : TYPE_MOUSE;
	assign cmp_match = rd_vld_s1 && (rd_data_s1.handle == handle_q) &&
		(!is_pkt || (rd_data_s1.dtype == want_type));
	assign shift_wr  = rd_vld_s1 && hit_q && (kind_q == KIND_REMOVE);
	assign scan_end  = (state_q == ST_SCAN) && !issue && !rd_vld_s1;
	assign fin       = (state_q == ST_FIN) && res_ready;
	assign is_full   = (live_q == CNT_W'(DEPTH));

	// Select the single write: compaction during scan, update or append at the end
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1 - 1'b1;
		wr_data = rd_data_s1;
		if (shift_wr) begin
			wr_en = 1'b1;
		end else if (fin && (kind_q == KIND_ASSIGN)) begin
			wr_data = '{dtype: dtype_q, ws: ws_q, handle: handle_q};
			if (hit_q) begin
				wr_en   = 1'b1;
				wr_addr = hit_idx_q;
			end else if (!is_full) begin
				wr_en   = 1'b1;
				wr_addr = live_q[IDX_W-1:0];
			end
		end
	end

	// Table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= entry_mem_q[rd_cnt_q[IDX_W-1:0]];
		rd_addr_s1 <= rd_cnt_q[IDX_W-1:0];
	end

	// Live count after this item
	always_comb begin
		live_next = live_q;
		unique case (kind_q)
			KIND_ASSIGN: if (!hit_q && !is_full) live_next = live_q + 1'b1;
			KIND_REMOVE: if (hit_q) live_next = live_q - 1'b1;
			KIND_CLEAR:  live_next = '0;
			default:     live_next = live_q;
		endcase
	end

	// Result fields
	always_comb begin
		res_status = STAT_OK;
		unique case (kind_q)
			KIND_ASSIGN: if (!hit_q && is_full) res_status = STAT_FULL;
			KIND_REMOVE: if (!hit_q) res_status = STAT_NOTFOUND;
			default:     res_status = STAT_OK;
		endcase
	end

	assign res_found = (hit_q && (is_pkt || (kind_q == KIND_LOOKUP))) ? hit_ws_q : NO_WS;
	assign res_count = live_next;
	assign res_valid = (state_q == ST_FIN);
	assign cmd_ready = (state_q == ST_IDLE);

	assign evt.fire      = fin;
	assign evt.is_packet = is_pkt;
	assign evt.is_clear  = (kind_q == KIND_CLEAR);

	// Hold the command fields for the duration of the item
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			kind_q   <= cmd_kind;
			handle_q <= cmd_handle;
			ws_q     <= cmd_ws;
			dtype_q  <= cmd_dtype;
		end
		if (cmp_match && !hit_q) begin
			hit_idx_q <= rd_addr_s1;
			hit_ws_q  <= rd_data_s1.ws;
		end
	end

	// Sequencer, read pipeline and first-match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			live_q    <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmp_match) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						rd_cnt_q <= '0;
						hit_q    <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						live_q  <= live_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/irt_stats.sv
// ----------------------------------------------------------------------------
// irt_stats - routing decision and packet counters
// Holds the routing enable register, decides routed or blocked for each
// packet and keeps the wrapping routed, blocked and total counters.
// ----------------------------------------------------------------------------
module irt_stats (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	input  irt_pkg::irt_evt_t         evt,
	input  logic [irt_pkg::WS_W-1:0]  found,
	output logic                      routed,
	output irt_pkg::irt_cnt_t         cnt_next
);
	import irt_pkg::*;

	logic     route_en_q;
	irt_cnt_t cnt_q;
	logic     blocked;

	// Decide the packet's fate
	assign blocked = route_en_q && (found == NO_WS);
	assign routed  = evt.is_packet && !blocked;

	// Counter values after this item
	always_comb begin
		cnt_next = cnt_q;
		if (evt.is_clear) begin
			cnt_next = '0;
		end else if (evt.is_packet) begin
			cnt_next.total = cnt_q.total + 1'b1;
			if (blocked) begin
				cnt_next.blocked = cnt_q.blocked + 1'b1;
			end else begin
				cnt_next.routed = cnt_q.routed + 1'b1;
			end
		end
	end

	// Register write and counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_en_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				route_en_q <= cfg_wr_data;
			end
			if (evt.fire) begin
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

// File: hdl/input_source_route_table.sv
// ----------------------------------------------------------------------------
// input_source_route_table - source handle to workspace routing table
// Maps input source handles to workspaces and device types, answers
// lookups and decides whether keyboard and mouse packets are routed.
//
// Channel   Direction  Content
// s_axis    in         tuser: kind[2:0]; tdata: handle, workspace, type
// m_axis    out        tuser: status[1:0]; tdata: workspace, routed, count,
//                      routed/blocked/packet totals
// cfg       in         cfg_wr_en / cfg_wr_data: route enable bit
//
// One item at a time; an item scans the live entries, reading one table entry
// per cycle from the table memory, then drains the read pipeline and takes
// the final step.
// A finished result waits in the output register while the next item scans.
// Reset empties the table and clears counters and route enable; no clearing
// pass is needed since only live entries are read.
// A stalled output holds the engine in its final step until the result is taken.
// ----------------------------------------------------------------------------
module input_source_route_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] source_handle, [63:32] workspace_id, [71:64] device_type
	input  logic [irt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// [2:0] kind
	input  logic [irt_pkg::S_TUSER_W-1:0]    s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] found_workspace, [32] routed, [39:33] entry_count,
	// [71:40] routed_total, [103:72] blocked_total, [135:104] packet_total
	output logic [irt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [1:0] status
	output logic [irt_pkg::M_TUSER_W-1:0]    m_axis_tuser,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data
);
	import irt_pkg::*;

	logic                  res_ready;
	logic                  res_valid;
	logic [STATUS_W-1:0]   res_status;
	logic [WS_W-1:0]       res_found;
	logic [CNT_W-1:0]      res_count;
	irt_evt_t              evt;
	logic                  routed;
	irt_cnt_t              cnt_next;
	logic                  out_vld_q;
	logic [M_TDATA_W-1:0]  out_data_q;
	logic [M_TUSER_W-1:0]  out_user_q;

	irt_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (s_axis_tvalid),
		.cmd_ready  (s_axis_tready),
		.cmd_kind   (s_axis_tuser),
		.cmd_handle (s_axis_tdata[31:0]),
		.cmd_ws     (s_axis_tdata[63:32]),
		.cmd_dtype  (s_axis_tdata[71:64]),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res_status (res_status),
		.res_found  (res_found),
		.res_count  (res_count),
		.evt        (evt)
	);

	irt_stats u_stats (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.evt         (evt),
		.found       (res_found),
		.routed      (routed),
		.cnt_next    (cnt_next)
	);

	// Output register is free when empty or being drained
	assign res_ready = !out_vld_q || m_axis_tready;

	// Load the result payload
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_user_q <= res_status;
			out_data_q <= {cnt_next.total, cnt_next.blocked, cnt_next.routed,
				ECOUNT_W'(res_count), routed, res_found};
		end
	end

	// Track output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// File: hdl/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker - port-level assertions for the route table
// Watches the top-level ports and checks handshake and result consistency.
// ----------------------------------------------------------------------------
module irt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [irt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input logic [irt_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
	import irt_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Busy right after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a second item while scanning");

	// Entry count never exceeds the table depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[39:33] <= ECOUNT_W'(DEPTH)))
		else $error("entry count beyond depth");

	// Table full only with a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STAT_FULL) |->
		(m_axis_tdata[39:33] == ECOUNT_W'(DEPTH)))
		else $error("full status with free entries");

	// A routed packet always reports ok
	a_routed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> (m_axis_tuser == STAT_OK))
		else $error("routed result with error status");

endmodule

bind input_source_route_table irt_checker u_irt_checker (.*);

// File: tb/route_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// route_check_pkg - result predictor and scoreboard for the route table
// Keeps a private copy of the source table, the counters and the route
// enable bit, works out the result of every accepted command and checks
// each returned result against the oldest outstanding one.
// ----------------------------------------------------------------------------
package route_check_pkg;

	import irt_pkg::*;

	// One result as seen on the master side
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WS_W-1:0]     workspace;
		logic                routed;
		logic [ECOUNT_W-1:0] count;
		logic [CTR_W-1:0]    routed_total;
		logic [CTR_W-1:0]    blocked_total;
		logic [CTR_W-1:0]    packet_total;
	} route_result_t;

	class route_scoreboard;

		logic [HANDLE_W-1:0] handle_tab [DEPTH];
		logic [WS_W-1:0]     ws_tab [DEPTH];
		logic [DTYPE_W-1:0]  type_tab [DEPTH];
		int                  live;
		logic [CTR_W-1:0]    n_routed;
		logic [CTR_W-1:0]    n_blocked;
		logic [CTR_W-1:0]    n_packets;
		bit                  route_en;
		route_result_t       expected_results [$];
		int unsigned         errors;

		function new();
			live      = 0;
			n_routed  = '0;
			n_blocked = '0;
			n_packets = '0;
			route_en  = 1'b0;
			errors    = 0;
		endfunction

		function void set_route_enable(bit v);
			route_en = v;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// First live entry matching the handle (and the type when asked), or -1
		function int find_entry(logic [HANDLE_W-1:0] handle, bit by_type,
				logic [DTYPE_W-1:0] dtype);
			for (int i = 0; i < live; i++) begin
				if (handle_tab[i] == handle && (!by_type || type_tab[i] == dtype))
					return i;
			end
			return -1;
		endfunction

		// Apply one accepted command to the shadow table and queue its result
		function void note_command(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
				logic [WS_W-1:0] ws, logic [DTYPE_W-1:0] dtype);
			route_result_t r;
			int idx;
			r.status    = STAT_OK;
			r.workspace = NO_WS;
			r.routed    = 1'b0;
			case (kind)
				KIND_ASSIGN: begin
					idx = find_entry(handle, 1'b0, '0);
					if (idx >= 0) begin
						ws_tab[idx]   = ws;
						type_tab[idx] = dtype;
					end else if (live >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						handle_tab[live] = handle;
						ws_tab[live]     = ws;
						type_tab[live]   = dtype;
						live++;
					end
				end
				KIND_REMOVE: begin
					idx = find_entry(handle, 1'b0, '0);
					if (idx >= 0) begin
						// close the gap by shifting later entries down
						for (int j = idx; j + 1 < live; j++) begin
							handle_tab[j] = handle_tab[j + 1];
							ws_tab[j]     = ws_tab[j + 1];
							type_tab[j]   = type_tab[j + 1];
						end
						live--;
					end else begin
						r.status = STAT_NOTFOUND;
					end
				end
				KIND_LOOKUP: begin
					idx = find_entry(handle, 1'b0, '0);
					if (idx >= 0)
						r.workspace = ws_tab[idx];
				end
				KIND_KEY, KIND_MOUSE: begin
					idx = find_entry(handle, 1'b1,
						(kind == KIND_KEY) ? TYPE_KEYBOARD : TYPE_MOUSE);
					if (idx >= 0)
						r.workspace = ws_tab[idx];
					if (route_en && r.workspace == NO_WS) begin
						n_blocked++;
					end else begin
						r.routed = 1'b1;
						n_routed++;
					end
					n_packets++;
				end
				KIND_CLEAR: begin
					live      = 0;
					n_routed  = '0;
					n_blocked = '0;
					n_packets = '0;
				end
				default: ;
			endcase
			r.count         = ECOUNT_W'(live);
			r.routed_total  = n_routed;
			r.blocked_total = n_blocked;
			r.packet_total  = n_packets;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			end
		endfunction

		// Unpack one transfer from the master side and check it field by field
		function void check_result(logic [M_TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata);
			route_result_t exp_r;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding, status %h data %h",
					$time, tuser, tdata);
				return;
			end
			exp_r = expected_results.pop_front();
			compare_field("status", exp_r.status, tuser);
			compare_field("found_workspace", exp_r.workspace, tdata[31:0]);
			compare_field("routed", exp_r.routed, tdata[32]);
			compare_field("entry_count", exp_r.count, tdata[39:33]);
			compare_field("routed_total", exp_r.routed_total, tdata[71:40]);
			compare_field("blocked_total", exp_r.blocked_total, tdata[103:72]);
			compare_field("packet_total", exp_r.packet_total, tdata[135:104]);
		endfunction

	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the input source route table
// Drives table commands and packets through the slave stream with random
// gaps, stalls the result stream in bursts and once for a long stretch,
// and checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

	import irt_pkg::*;
	import route_check_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 80;
	localparam int POOL_SIZE      = 80;

	// Kinds the block treats as no-ops
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic                 cfg_wr_en;
	logic                 cfg_wr_data;

	route_scoreboard      sb;
	logic [HANDLE_W-1:0]  handle_pool [POOL_SIZE];
	bit                   quiet;
	bit                   hold_request;
	int                   quiet_cycles;

	input_source_route_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one command and hold it until the transfer happens
	task automatic send_command(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] handle,
			input logic [WS_W-1:0] ws, input logic [DTYPE_W-1:0] dtype);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {dtype, ws, handle};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.note_command(kind, handle, ws, dtype);
	endtask

	// Sometimes drop tvalid for a gap of random length
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	endtask

	// Drop tvalid and hold off until every result has been taken
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_route_enable(input bit v);
		drain_results();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		sb.set_route_enable(v);
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	function automatic logic [DTYPE_W-1:0] random_device_type();
		if ($urandom_range(0, 3) == 0)
			return DTYPE_W'($urandom_range(0, 255));
		return $urandom_range(0, 1) ? TYPE_KEYBOARD : TYPE_MOUSE;
	endfunction

	function automatic logic [WS_W-1:0] random_workspace();
		case ($urandom_range(0, 7))
			0: return NO_WS;
			1: return WS_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [HANDLE_W-1:0] random_handle(input int pool_n);
		if ($urandom_range(0, 15) == 0)
			return $urandom;
		return handle_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	// One random command over the first pool_n handles of the pool
	task automatic random_command(input int pool_n);
		int r;
		logic [KIND_W-1:0] kind;
		r = $urandom_range(0, 99);
		if (r < 30)      kind = KIND_ASSIGN;
		else if (r < 42) kind = KIND_REMOVE;
		else if (r < 54) kind = KIND_LOOKUP;
		else if (r < 72) kind = KIND_KEY;
		else if (r < 90) kind = KIND_MOUSE;
		else if (r < 93) kind = KIND_CLEAR;
		else if (r < 96) kind = KIND_SPARE_A;
		else             kind = KIND_SPARE_B;
		sender_gap();
		send_command(kind, random_handle(pool_n), random_workspace(), random_device_type());
	endtask

	// Fill the table past capacity, mixing in searches and a few removes
	task automatic fill_table();
		int i;
		logic [KIND_W-1:0] kind;
		i = 0;
		while (i < POOL_SIZE) begin
			if (i == 20)
				hold_request = 1'b1;
			sender_gap();
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: kind = KIND_LOOKUP;
					1: kind = KIND_KEY;
					2: kind = KIND_MOUSE;
					default: kind = KIND_REMOVE;
				endcase
				send_command(kind, random_handle(i + 1), random_workspace(),
					random_device_type());
			end else begin
				send_command(KIND_ASSIGN, handle_pool[i], random_workspace(),
					random_device_type());
				i++;
			end
		end
		// top up with fresh handles until every entry is taken
		while (sb.live < DEPTH)
			send_command(KIND_ASSIGN, $urandom, random_workspace(), random_device_type());
		// fresh handles on a full table, then updates of known ones
		repeat (4) send_command(KIND_ASSIGN, $urandom, random_workspace(), random_device_type());
		repeat (4) send_command(KIND_ASSIGN, handle_pool[$urandom_range(0, POOL_SIZE - 1)],
			random_workspace(), random_device_type());
	endtask

	// Result side: random stall bursts, one long hold, check each transfer
	initial begin
		int burst;
		burst         = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request  = 1'b0;
				m_axis_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (burst > 0) begin
				burst--;
				m_axis_tready = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst         = $urandom_range(0, 15);
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready)
				sb.check_result(m_axis_tuser, m_axis_tdata);
		end
	end

	// Watchdog: end the run after too many cycles with no transfer
	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
					(m_axis_tvalid === 1'b1 && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("input_source_route_table: mismatch");
		$finish;
	end

	// Stimulus
	initial begin
		sb            = new();
		quiet         = 1'b0;
		hold_request  = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 1'b0;
		handle_pool[0] = '0;
		handle_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			handle_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, updates, type matching, no-op kinds
		write_route_enable(1'b0);
		send_command(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_REMOVE, 32'h0000_1234, 32'h0000_0000, 8'h00);
		send_command(KIND_KEY,    32'h0000_0005, 32'h0000_0000, 8'h00);
		send_command(KIND_ASSIGN, 32'h0000_0000, 32'h0000_0000, TYPE_KEYBOARD);
		send_command(KIND_ASSIGN, 32'hFFFF_FFFF, NO_WS, TYPE_MOUSE);
		send_command(KIND_ASSIGN, 32'h0000_0000, 32'h1234_5678, TYPE_MOUSE);
		send_command(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
		send_command(KIND_KEY,    32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_MOUSE,  32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_command(KIND_SPARE_B, 32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_ASSIGN, 32'h0000_0007, 32'h0000_0001, 8'hFF);
		send_command(KIND_MOUSE,  32'h0000_0007, 32'h0000_0000, 8'h00);

		// Directed with routing enabled: blocking, shift on remove, clear
		write_route_enable(1'b1);
		send_command(KIND_KEY,    32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_MOUSE,  32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_MOUSE,  32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
		send_command(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
		send_command(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_CLEAR,  32'h0000_0000, 32'h0000_0000, 8'h00);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
		send_command(KIND_KEY,    32'h0000_0001, 32'h0000_0000, 8'h00);

		// Random: fill to capacity under a long result stall
		fill_table();

		write_route_enable(1'b0);
		repeat (150) random_command(8);

		write_route_enable(1'b1);
		repeat (150) random_command(24);

		// Final stretch without any idling
		write_route_enable(1'b0);
		quiet = 1'b1;
		repeat (80) random_command(12);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("input_source_route_table: match");
		else
			$display("input_source_route_table: mismatch");
		$finish;
	end

endmodule
